// ===== sv/assert_macros.svh =====
// Assertion macros used by the allocator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/zba_pkg.sv =====
// Package for the zone bitmap allocator: sizes, codes and the bit search.
package zba_pkg;

  localparam int MAP_WORDS  = 2048;
  // Bits per map word; keep it a power of two.
  localparam int WORD_BITS  = 32;
  localparam int WORD_IDX_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_IDX_W  = $clog2(WORD_BITS);
  localparam int BIT_W      = WORD_IDX_W + BIT_IDX_W;
  localparam int CNT_W      = WORD_IDX_W + 1;
  localparam int ZONE_W     = 16;
  localparam int CFG_W      = 16;
  localparam int EXT_W      = ((BIT_W > ZONE_W) ? BIT_W : ZONE_W) + 2;
  localparam int TOTAL_BITS = MAP_WORDS * WORD_BITS;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FREED = 2'd3
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic {
    CFG_FIRST_DATA_ZONE = 1'b0,
    CFG_NUM_ZONES       = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FREE_CHK,
    ST_DONE
  } state_t;

  // Index of the lowest clear bit; zero when the word is full.
  function automatic logic [BIT_IDX_W-1:0] lowest_clear(input logic [WORD_BITS-1:0] w);
    logic [BIT_IDX_W-1:0] k;
    k = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) k = BIT_IDX_W'(i);
    end
    return k;
  endfunction

endpackage

// ===== sv/zba_ram.sv =====
// Generic simple dual-port RAM with a registered read.
module zba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/zone_bitmap_allocator.sv =====
// Top level of the zone bitmap allocator: first-fit allocation and frees on a RAM bitmap.
// Allocate: map words are read in order from word 0 until one has a clear bit or the
// last word is checked. Free: the zone's word is read, then its bit is cleared if set;
// an out-of-range zone goes straight to the result. One word in flight at a time: the
// next word can be taken in the cycle after the result loads.
// Reset: a clearing sweep writes all MAP_WORDS (2048) words, one per cycle, with
// in_ready low; word 0 gets its reserved bit set. Config writes are taken throughout.
module zone_bitmap_allocator
  import zba_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // request channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              op,
  input  logic [ZONE_W-1:0] zone_in,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        status,
  output logic [ZONE_W-1:0] zone_out,
  // configuration write port
  input  logic              cfg_wen,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

`include "assert_macros.svh"

  localparam logic [WORD_IDX_W-1:0] LAST_WORD = WORD_IDX_W'(MAP_WORDS - 1);

  state_t state, state_next;

  // configuration registers
  logic [ZONE_W-1:0] first_data_zone;
  logic [ZONE_W-1:0] num_zones;

  // sweep, scan and free bookkeeping
  logic [WORD_IDX_W-1:0] clr_addr;
  logic [CNT_W-1:0]      scan_addr;   // next word to read
  logic [WORD_IDX_W-1:0] chk_addr;    // word whose data sits on the RAM output
  logic [WORD_IDX_W-1:0] free_word;
  logic [BIT_IDX_W-1:0]  free_bit;
  status_t               res_status;
  logic [ZONE_W-1:0]     res_zone;

  // RAM port signals
  logic [WORD_IDX_W-1:0] rd_addr;
  logic [WORD_BITS-1:0]  rd_data;
  logic                  wr_en;
  logic [WORD_IDX_W-1:0] wr_addr;
  logic [WORD_BITS-1:0]  wr_data;

  logic in_fire;
  logic out_load;

  // free-path arithmetic in the extended width; b_free wraps only when zone_in < first
  logic [EXT_W-1:0] zin_ext, first_ext, lim_ext, b_free;
  logic             free_range_err;

  // scan-path search on the word coming out of the RAM
  logic                 found;
  logic [BIT_IDX_W-1:0] k;
  logic [EXT_W-1:0]     zone_ext;
  logic                 alloc_ok;
  logic                 bit_set;

  zba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign in_fire  = in_valid && in_ready;
  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);

  assign zin_ext   = EXT_W'(zone_in);
  assign first_ext = EXT_W'(first_data_zone);
  assign lim_ext   = EXT_W'(num_zones);
  // Bit index of the zone to free; only meaningful when zone_in >= first.
  assign b_free    = zin_ext - first_ext + EXT_W'(1);
  assign free_range_err = (zin_ext < first_ext) || (zin_ext >= lim_ext) ||
                          (b_free >= EXT_W'(TOTAL_BITS));

  // Bit 0 of the map never clears, so the found bit index is at least one
  // and the zone below cannot go negative.
  assign found    = |(~rd_data);
  assign k        = lowest_clear(rd_data);
  assign zone_ext = EXT_W'({chk_addr, k}) + first_ext - EXT_W'(1);
  assign alloc_ok = found && (zone_ext < lim_ext);
  assign bit_set  = rd_data[free_bit];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == LAST_WORD) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (op_t'(op) == OP_ALLOC) state_next = ST_SCAN;
          else if (free_range_err) state_next = ST_DONE;
          else state_next = ST_FREE_CHK;
        end
      end
      ST_SCAN: begin
        // stop at the first word with a clear bit, or after the last word
        if (found || chk_addr == LAST_WORD) state_next = ST_DONE;
      end
      ST_FREE_CHK: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // handshake and RAM controls
  always_comb begin
    in_ready = 1'b0;
    rd_addr  = scan_addr[WORD_IDX_W-1:0];
    wr_en    = 1'b0;
    wr_addr  = chk_addr;
    wr_data  = rd_data;
    case (state)
      ST_CLEAR: begin
        // sweep the map clear, keeping the reserved bit of word 0 set
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = (clr_addr == '0) ? WORD_BITS'(1) : '0;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        rd_addr  = (op_t'(op) == OP_ALLOC) ? '0 : b_free[BIT_W-1:BIT_IDX_W];
      end
      ST_SCAN: begin
        // claim the bit only when its zone lies inside the volume
        if (alloc_ok) begin
          wr_en   = 1'b1;
          wr_addr = chk_addr;
          wr_data = rd_data | (WORD_BITS'(1) << k);
        end
      end
      ST_FREE_CHK: begin
        wr_addr = free_word;
        if (bit_set) begin
          wr_en   = 1'b1;
          wr_data = rd_data & ~(WORD_BITS'(1) << free_bit);
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      clr_addr        <= '0;
      out_valid       <= 1'b0;
      first_data_zone <= ZONE_W'(1);
      num_zones       <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + WORD_IDX_W'(1);
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cfg_wen) begin
        case (cfg_idx_t'(cfg_index))
          CFG_FIRST_DATA_ZONE: first_data_zone <= cfg_wdata;
          CFG_NUM_ZONES:       num_zones       <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          chk_addr   <= '0;
          scan_addr  <= CNT_W'(1);
          free_word  <= b_free[BIT_W-1:BIT_IDX_W];
          free_bit   <= b_free[BIT_IDX_W-1:0];
          res_status <= STAT_RANGE;
          res_zone   <= '0;
        end
      end
      ST_SCAN: begin
        // advance the read pipeline one word per cycle
        chk_addr  <= scan_addr[WORD_IDX_W-1:0];
        scan_addr <= scan_addr + CNT_W'(1);
        if (alloc_ok) begin
          res_status <= STAT_OK;
          res_zone   <= zone_ext[ZONE_W-1:0];
        end else begin
          res_status <= STAT_FULL;
          res_zone   <= '0;
        end
      end
      ST_FREE_CHK: begin
        res_status <= bit_set ? STAT_OK : STAT_FREED;
        res_zone   <= '0;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      status   <= res_status;
      zone_out <= res_zone;
    end
  end

  // one word at a time: no second accept right after the first
  `ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
  // an error result never carries a zone number
  `ASSERT_NOW(a_err_zone_zero, out_valid && status != STAT_OK, zone_out == '0)
  // a write to word 0, in the sweep or outside it, keeps the reserved bit set
  `ASSERT_NOW(a_reserved_bit, wr_en && wr_addr == '0, wr_data[0])
  // read address runs exactly one word ahead of the checked word during a scan
  `ASSERT_NOW(a_scan_lead, state == ST_SCAN, scan_addr == CNT_W'(chk_addr) + CNT_W'(1))

endmodule
